// File: hw/rtl/msw_pkg.sv
// Shared types and constants for the morphing sawtooth waveshaper.
package msw_pkg;

  // Q1.15 unity
  localparam logic [16:0] Q15_ONE   = 17'd32768;

  // Comparator level (0 + 0.2) * 0.4 in Q1.15, floored
  localparam logic signed [15:0] CMP_LEVEL = 16'sd2621;

  // Shared multiplier: signed A operand times unsigned B operand
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = 53;

  // Configuration register indexes
  localparam logic REG_PHASE_STEP  = 1'b0;
  localparam logic REG_OUTPUT_GAIN = 1'b1;

  // Operand selection for the shared multiplier
  typedef enum logic [2:0] {
    MUL_CMP,
    MUL_RECIP,
    MUL_QDIV,
    MUL_RECT,
    MUL_GAIN,
    MUL_OUT
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load_item;
    logic     setup;
    logic     cmp_take;
    logic     quo_take;
    logic     gains;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     y_calc;
    logic     sum_calc;
    logic     out_load;
  } msw_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } msw_status_t;

endpackage

// File: hw/rtl/msw_ctrl.sv
// Sequencing state machine for the morphing sawtooth waveshaper.
module msw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  msw_pkg::msw_status_t  status,
  output msw_pkg::msw_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_RECIP,
    S_QMUL,
    S_GAINS,
    S_RECT,
    S_YCALC,
    S_RMUL,
    S_SUM,
    S_OMUL,
    S_DONE
  } state_t;

  state_t state;

  // State sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SETUP;
        end
        S_SETUP: state <= S_RECIP;
        S_RECIP: state <= S_QMUL;
        S_QMUL:  state <= S_GAINS;
        S_GAINS: state <= S_RECT;
        S_RECT:  state <= S_YCALC;
        S_YCALC: state <= S_RMUL;
        S_RMUL:  state <= S_SUM;
        S_SUM:   state <= S_OMUL;
        S_OMUL:  state <= S_DONE;
        S_DONE: begin
          // hold the finished sample until the output register frees up
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd      = '0;
    in_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE:  cmd.load_item = in_valid;
      S_SETUP: begin
        cmd.setup   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = msw_pkg::MUL_CMP;
      end
      S_RECIP: begin
        cmd.cmp_take = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = msw_pkg::MUL_RECIP;
      end
      S_QMUL: begin
        cmd.quo_take = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = msw_pkg::MUL_QDIV;
      end
      S_GAINS: cmd.gains = 1'b1;
      S_RECT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = msw_pkg::MUL_RECT;
      end
      S_YCALC: cmd.y_calc = 1'b1;
      S_RMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = msw_pkg::MUL_GAIN;
      end
      S_SUM:   cmd.sum_calc = 1'b1;
      S_OMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = msw_pkg::MUL_OUT;
      end
      S_DONE:  cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: hw/rtl/msw_dp.sv
// Datapath: phase accumulator, reciprocal divider, shared multiplier and output register.
module msw_dp #(
  parameter int SPLIT_LOW  = 13107,
  parameter int SPLIT_HIGH = 26214
) (
  input  logic                  clk,
  input  logic                  rst,
  input  msw_pkg::msw_cmd_t     cmd,
  output msw_pkg::msw_status_t  status,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [15:0]           morph_position,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    audio_sample
);

  localparam int PW = msw_pkg::PROD_W;
  localparam int AW = msw_pkg::MUL_A_W;
  localparam int BW = msw_pkg::MUL_B_W;

  // Crossfade divisor; an empty or degenerate region gives zero
  localparam int CrossDiv = (SPLIT_HIGH > SPLIT_LOW) ? SPLIT_HIGH - SPLIT_LOW : 0;

  // Reciprocals floor(2^31 / divisor); (a * recip) >> 16 is low by at most one
  localparam longint RecipLow   = 64'sd2147483648 / longint'(SPLIT_LOW);
  localparam longint RecipCross = (CrossDiv > 0) ?
                                  64'sd2147483648 / longint'(CrossDiv) : 64'sd0;

  // Comparator-only threshold terms, all scaled by 10 * 2^15
  localparam longint CmpD10Raw = 64'sd393216 - 64'sd10 * longint'(SPLIT_HIGH);
  localparam longint CmpD10    = (CmpD10Raw < 1) ? 64'sd1 : CmpD10Raw;
  localparam longint CmpMul    = 64'sd25 * CmpD10;
  localparam longint CmpOfs    = 64'sd65536 * CmpD10;

  // Configuration and phase
  logic [31:0] phase_step;
  logic [15:0] output_gain;
  logic [31:0] phase;

  // Item state
  logic [15:0]          v;
  logic                 rect_r, comp_r, below_r, full_r;
  logic [15:0]          num;
  logic [14:0]          quo;
  logic [38:0]          rhs_mag;
  logic [16:0]          t, rgain, cgain;
  logic                 gt, x_gt_t;
  logic signed [PW-1:0] prod;
  logic signed [19:0]   y, sum;
  logic signed [15:0]   sample;
  logic                 valid;

  // Combinational terms
  logic signed [15:0]   x;
  logic signed [19:0]   x20, t20, half20, rq20, cg20, k20, y_n, sum_n;
  logic [15:0]          div_d, set_d, set_a, over, half;
  logic [16:0]          c_val;
  logic [14:0]          quo_n, quo_fix;
  logic [31:0]          rem_val;
  logic                 rem_ge, in_rect, in_comp, in_below, gt_n;
  logic [20:0]          cmp_mag;
  logic [22:0]          mag5;
  logic signed [PW-1:0] cmp_sum, prod_n;
  logic signed [AW-1:0] mul_a;
  logic [BW-1:0]        mul_b;
  logic signed [28:0]   q;
  logic signed [15:0]   sat;

  // Bipolar sawtooth from the top half of the phase
  assign x   = {~phase[31], phase[30:16]};
  assign x20 = {{4{x[15]}}, x};

  // Region classification and divider setup
  assign in_rect  = (v < 16'(SPLIT_LOW));
  assign in_comp  = (v > 16'(SPLIT_HIGH));
  assign in_below = (v < 16'(SPLIT_HIGH));
  assign set_d    = in_rect ? 16'(SPLIT_LOW) : 16'(CrossDiv);
  assign set_a    = in_rect ? v : v - 16'(SPLIT_LOW);

  // Comparator-only right-hand side magnitude: (16*(v-SH) + 163840) * 327680
  assign over    = v - 16'(SPLIT_HIGH);
  assign cmp_mag = {1'b0, over, 4'b0000} + 21'd163840;
  assign mag5    = {cmp_mag, 2'b00} + {2'b00, cmp_mag};

  // Quotient estimate from the reciprocal product, then one compare and subtract
  assign div_d   = rect_r ? 16'(SPLIT_LOW) : 16'(CrossDiv);
  assign quo_n   = prod[30:16];
  assign rem_val = {1'b0, num, 15'd0} - prod[31:0];
  assign rem_ge  = (rem_val >= {16'd0, div_d});
  assign quo_fix = quo + {14'd0, rem_ge};

  // Crossfade amount; a zero divisor or full-scale position is special
  always_comb begin
    if (CrossDiv == 0) c_val = '0;
    else if (full_r)   c_val = msw_pkg::Q15_ONE;
    else               c_val = {2'b00, quo_fix};
  end

  // Comparator decision: x*D - E > -rhs in the comparator-only region
  assign cmp_sum = prod - PW'(CmpOfs) + $signed(PW'(rhs_mag));
  assign gt_n    = comp_r ? (cmp_sum > 0) : (x > msw_pkg::CMP_LEVEL);

  // Shared multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      msw_pkg::MUL_CMP: begin
        mul_a = AW'(x20);
        mul_b = BW'(CmpMul);
      end
      msw_pkg::MUL_RECIP: begin
        mul_a = AW'({1'b0, num});
        mul_b = rect_r ? BW'(RecipLow) : BW'(RecipCross);
      end
      msw_pkg::MUL_QDIV: begin
        mul_a = AW'({1'b0, quo_n});
        mul_b = BW'(div_d);
      end
      msw_pkg::MUL_RECT: begin
        mul_a = AW'(x20);
        mul_b = BW'(t + msw_pkg::Q15_ONE);
      end
      msw_pkg::MUL_GAIN: begin
        mul_a = y;
        mul_b = BW'(rgain);
      end
      msw_pkg::MUL_OUT: begin
        mul_a = sum;
        mul_b = BW'(output_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_n = mul_a * $signed({1'b0, mul_b});

  // Rectifier: fold above threshold, then offset by half the headroom
  assign t20    = $signed({3'b000, t});
  assign half   = 16'((msw_pkg::Q15_ONE - t) >> 1);
  assign half20 = $signed({4'b0000, half});
  assign rq20   = prod[34:15];
  assign y_n    = x_gt_t ? (t20 - rq20 + half20) : (x20 + half20);

  // Comparator contribution: -gain, zero or +gain
  assign cg20  = $signed({3'b000, cgain});
  always_comb begin
    if (gt && below_r) k20 = -cg20;
    else if (gt)       k20 = '0;
    else               k20 = cg20;
  end
  assign sum_n = rq20 + k20;

  // Output scaling and saturation
  assign q = prod[44:16];
  always_comb begin
    if (q > 29'sd32767)       sat = 16'sh7fff;
    else if (q < -29'sd32768) sat = 16'sh8000;
    else                      sat = q[15:0];
  end

  // Control state: configuration, phase, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= '0;
      output_gain <= 16'h8000;
      phase       <= '0;
      valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          msw_pkg::REG_PHASE_STEP:  phase_step  <= cfg_data;
          msw_pkg::REG_OUTPUT_GAIN: output_gain <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.load_item) phase <= phase + phase_step;
      if (cmd.out_load)  valid <= 1'b1;
      else if (out_ready) valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) v <= morph_position;
    if (cmd.setup) begin
      rect_r  <= in_rect;
      comp_r  <= in_comp;
      below_r <= in_below;
      full_r  <= (set_a >= set_d);
      num     <= set_a;
      rhs_mag <= {mag5, 16'h0000};
    end
    if (cmd.cmp_take) gt  <= gt_n;
    if (cmd.quo_take) quo <= quo_n;
    if (cmd.gains) begin
      priority if (rect_r) begin
        t     <= {2'b00, quo_fix};
        rgain <= msw_pkg::Q15_ONE;
        cgain <= '0;
      end else if (comp_r) begin
        t     <= msw_pkg::Q15_ONE;
        rgain <= '0;
        cgain <= msw_pkg::Q15_ONE;
      end else begin
        t     <= msw_pkg::Q15_ONE;
        rgain <= msw_pkg::Q15_ONE - c_val;
        cgain <= c_val;
      end
    end
    if (cmd.mul_en) begin
      prod <= prod_n;
      if (cmd.mul_sel == msw_pkg::MUL_RECT) x_gt_t <= (x20 > t20);
    end
    if (cmd.y_calc)   y      <= y_n;
    if (cmd.sum_calc) sum    <= sum_n;
    if (cmd.out_load) sample <= sat;
  end

  assign status.out_free = !valid || out_ready;
  assign out_valid       = valid;
  assign audio_sample    = sample;

endmodule

// File: hw/rtl/morphing_sawtooth_waveshaper_unit.sv
// Morphing sawtooth waveshaper: top level joining controller and datapath.
//
// Usage:
//   Input channel (in_valid/in_ready, morph_position): one request per audio
//   sample tick. Each accepted request advances the 32-bit phase by
//   phase_step and produces exactly one audio_sample on the output channel
//   (out_valid/out_ready).
//   Configuration: cfg_write with cfg_index 0 sets phase_step, index 1 sets
//   output_gain (cfg_data[15:0]). Write only while no request is in flight.
//   Sequencing: out_valid rises once the output register is loaded. No new
//   request is taken until the current one leaves the done state; the
//   reciprocal-multiply division for the threshold and crossfade amount and
//   the six passes through the single shared multiplier set the pace.
//   Stall: the result sits in an output register, so the next request is
//   taken while it waits; if a second result is done before the first is
//   taken, the controller holds it until the output register frees up.
//   Reset (rst, synchronous): phase 0, phase_step 0, output_gain unity,
//   output empty, ready for a request on the next cycle.
module morphing_sawtooth_waveshaper_unit #(
  parameter int SPLIT_LOW  = 13107,
  parameter int SPLIT_HIGH = 26214
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        morph_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] audio_sample,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  msw_pkg::msw_cmd_t    cmd;
  msw_pkg::msw_status_t status;

  // Sequencer
  msw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and storage
  msw_dp #(
    .SPLIT_LOW  (SPLIT_LOW),
    .SPLIT_HIGH (SPLIT_HIGH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .morph_position (morph_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .audio_sample   (audio_sample)
  );

endmodule
